/* sv/m3inv_pkg.sv */
// ----------------------------------------------------------------------------
// m3inv_pkg
// types, constants and fixed-point helpers for the 3x3 inverse core
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int NUM_LANES = 9;
  localparam int DIV_LAT   = NUM_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] uword_t;
  typedef logic        [NUM_BITS-1:0]  num_t;

  typedef struct packed {
    word_t a00; word_t a01; word_t a02;
    word_t a10; word_t a11; word_t a12;
    word_t a20; word_t a21; word_t a22;
  } in_item_t;

  typedef struct packed {
    word_t inv00; word_t inv01; word_t inv02;
    word_t inv10; word_t inv11; word_t inv12;
    word_t inv20; word_t inv21; word_t inv22;
    word_t det_value;
    logic  singular;
  } out_item_t;

  localparam word_t WMAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WMIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  // rounded, saturated product from a full signed product
  function automatic word_t fx_round(input logic signed [PROD_BITS-1:0] p);
    logic                 neg;
    logic [PROD_BITS-1:0] m;
    logic [PROD_BITS-1:0] r;
    logic [PROD_BITS-1:0] lim;
    begin
      neg = p[PROD_BITS-1];
      m   = neg ? (~p + 1'b1) : p;
      r   = (m + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      lim = neg ? PROD_BITS'(WMIN) & PROD_BITS'({1'b0, {(WORD_BITS){1'b1}}}) 
                : PROD_BITS'(WMAX);
      if (r > lim) r = lim;
      fx_round = neg ? word_t'(~r[WORD_BITS-1:0] + 1'b1) : word_t'(r[WORD_BITS-1:0]);
    end
  endfunction

  function automatic word_t fx_addsat(input word_t a, input word_t b, input logic sub);
    logic signed [WORD_BITS:0] s;
    begin
      s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
              : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
      if (s[WORD_BITS] != s[WORD_BITS-1]) fx_addsat = s[WORD_BITS] ? WMIN : WMAX;
      else fx_addsat = word_t'(s[WORD_BITS-1:0]);
    end
  endfunction

endpackage

/* sv/m3inv_div.sv */
// ----------------------------------------------------------------------------
// m3inv_div
// pipelined restoring divider lane, one quotient bit per stage, round and saturate
// ----------------------------------------------------------------------------
module m3inv_div (
  input  logic                 clk,
  input  logic                 en,
  input  m3inv_pkg::word_t     num,
  input  m3inv_pkg::word_t     den,
  output m3inv_pkg::word_t     quo
);

  localparam int NB = m3inv_pkg::NUM_BITS;
  localparam int WB = m3inv_pkg::WORD_BITS;

  logic [NB-1:0] n_r   [NB+1];
  logic [NB-1:0] q_r   [NB+1];
  logic [WB:0]   rem_r [NB+1];
  logic [WB-1:0] d_r   [NB+1];
  logic          neg_r [NB+1];

  logic [WB-1:0] mn;
  logic [WB-1:0] md;
  assign mn = num[WB-1] ? (~num + 1'b1) : num;
  assign md = den[WB-1] ? (~den + 1'b1) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= {mn, {m3inv_pkg::FRAC_BITS{1'b0}}};
      q_r[0]   <= '0;
      rem_r[0] <= '0;
      d_r[0]   <= md;
      neg_r[0] <= num[WB-1] ^ den[WB-1];
    end
  end

  for (genvar s = 0; s < NB; s++) begin : g_stage
    logic [WB:0] sh;
    logic        ge;
    assign sh = {rem_r[s][WB-1:0], n_r[s][NB-1]};
    assign ge = sh >= {1'b0, d_r[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? sh - {1'b0, d_r[s]} : sh;
        q_r[s+1]   <= {q_r[s][NB-2:0], ge};
        n_r[s+1]   <= {n_r[s][NB-2:0], 1'b0};
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  logic [NB:0]   qr;
  logic [NB:0]   lim;
  logic [WB+1:0] rem2;
  always_comb begin
    rem2 = {rem_r[NB], 1'b0};
    qr   = {1'b0, q_r[NB]} + ((rem2 >= {2'b0, d_r[NB]}) ? 1'b1 : 1'b0);
    lim  = neg_r[NB] ? (NB+1)'({1'b1, {(WB-1){1'b0}}}) : (NB+1)'({(WB-1){1'b1}});
    if (qr > lim) qr = lim;
    quo = neg_r[NB] ? m3inv_pkg::word_t'(~qr[WB-1:0] + 1'b1)
                    : m3inv_pkg::word_t'(qr[WB-1:0]);
  end

endmodule

/* sv/m3inv_cof.sv */
// ----------------------------------------------------------------------------
// m3inv_cof
// cofactor lane: two products, rounding, saturating difference
// ----------------------------------------------------------------------------
module m3inv_cof (
  input  logic             clk,
  input  logic             en,
  input  m3inv_pkg::word_t x0,
  input  m3inv_pkg::word_t y0,
  input  m3inv_pkg::word_t x1,
  input  m3inv_pkg::word_t y1,
  output m3inv_pkg::word_t cof
);

  logic signed [m3inv_pkg::PROD_BITS-1:0] p0_r;
  logic signed [m3inv_pkg::PROD_BITS-1:0] p1_r;
  m3inv_pkg::word_t                       cof_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= x0 * y0;
      p1_r  <= x1 * y1;
      cof_r <= m3inv_pkg::fx_addsat(m3inv_pkg::fx_round(p0_r),
                                    m3inv_pkg::fx_round(p1_r), 1'b1);
    end
  end

  assign cof = cof_r;

endmodule

/* sv/matrix3x3_inverse_core.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// 3x3 Q16.16 matrix inverse by adjugate over determinant
// ----------------------------------------------------------------------------
// in_valid/in_stall carry one matrix per transaction, out_valid/out_stall one
// inverse, determinant and singular flag per transaction.
// nine cofactor lanes (two products and a difference) work side by side,
// the determinant takes three more products and two adds, then nine divider
// lanes each give one quotient bit per stage.
// a matrix passes the input register, the cofactor lanes, the determinant,
// the divider stages (most of the depth) and the merge stage before its result can be accepted.
// throughput: one matrix per cycle while no result-side stall freezes the pipeline.
// the whole pipeline advances together; a stall on the result side with
// the last stage full freezes every stage and raises in_stall.
// a singular matrix gives zeros with singular set.
// reset clears the valid bits of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  m3inv_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output m3inv_pkg::out_item_t  out_data
);

  localparam int LAT = 5 + m3inv_pkg::DIV_LAT + 2;

  logic             en;
  logic [LAT-1:0]   v_r;
  m3inv_pkg::word_t c  [9];
  m3inv_pkg::word_t q  [9];
  m3inv_pkg::in_item_t a_r, a1_r, a2_r;
  m3inv_pkg::word_t c_r [9];
  logic signed [m3inv_pkg::PROD_BITS-1:0] d0_r, d1_r, d2_r;
  m3inv_pkg::word_t det_r;
  m3inv_pkg::word_t dpipe_r [m3inv_pkg::DIV_LAT+1];
  m3inv_pkg::out_item_t o_r;

  assign en       = !(v_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= in_data;
      a1_r <= a_r;
      a2_r <= a1_r;
    end
  end

  m3inv_cof u_c00 (.clk, .en, .x0(a_r.a11), .y0(a_r.a22), .x1(a_r.a12), .y1(a_r.a21), .cof(c[0]));
  m3inv_cof u_c01 (.clk, .en, .x0(a_r.a12), .y0(a_r.a20), .x1(a_r.a10), .y1(a_r.a22), .cof(c[1]));
  m3inv_cof u_c02 (.clk, .en, .x0(a_r.a10), .y0(a_r.a21), .x1(a_r.a11), .y1(a_r.a20), .cof(c[2]));
  m3inv_cof u_c10 (.clk, .en, .x0(a_r.a02), .y0(a_r.a21), .x1(a_r.a01), .y1(a_r.a22), .cof(c[3]));
  m3inv_cof u_c11 (.clk, .en, .x0(a_r.a00), .y0(a_r.a22), .x1(a_r.a02), .y1(a_r.a20), .cof(c[4]));
  m3inv_cof u_c12 (.clk, .en, .x0(a_r.a01), .y0(a_r.a20), .x1(a_r.a00), .y1(a_r.a21), .cof(c[5]));
  m3inv_cof u_c20 (.clk, .en, .x0(a_r.a01), .y0(a_r.a12), .x1(a_r.a02), .y1(a_r.a11), .cof(c[6]));
  m3inv_cof u_c21 (.clk, .en, .x0(a_r.a02), .y0(a_r.a10), .x1(a_r.a00), .y1(a_r.a12), .cof(c[7]));
  m3inv_cof u_c22 (.clk, .en, .x0(a_r.a00), .y0(a_r.a11), .x1(a_r.a01), .y1(a_r.a10), .cof(c[8]));

  // determinant: products, then saturating adds
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) c_r[i] <= c[i];
      d0_r  <= a2_r.a00 * c[0];
      d1_r  <= a2_r.a01 * c[1];
      d2_r  <= a2_r.a02 * c[2];
      det_r <= m3inv_pkg::fx_addsat(
                 m3inv_pkg::fx_addsat(m3inv_pkg::fx_round(d0_r),
                                      m3inv_pkg::fx_round(d1_r), 1'b0),
                 m3inv_pkg::fx_round(d2_r), 1'b0);
    end
  end

  // cofactors pass a further register, cd_r, to line up with det_r
  m3inv_pkg::word_t cd_r [9];
  always_ff @(posedge clk) begin
    if (en) for (int i = 0; i < 9; i++) cd_r[i] <= c_r[i];
  end

  // det zero is replaced by 1 LSB so dividers stay defined; result is masked
  m3inv_pkg::word_t dsafe;
  assign dsafe = (det_r == '0) ? m3inv_pkg::word_t'(1) : det_r;

  // inv(r,k) = C(k,r) / det
  for (genvar l = 0; l < 9; l++) begin : g_div
    m3inv_div u_div (.clk, .en, .num(cd_r[(l % 3) * 3 + (l / 3)]), .den(dsafe), .quo(q[l]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpipe_r[0] <= det_r;
      for (int i = 1; i <= m3inv_pkg::DIV_LAT; i++) dpipe_r[i] <= dpipe_r[i-1];
    end
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      if (dpipe_r[m3inv_pkg::DIV_LAT] == '0) begin
        o_r <= m3inv_pkg::out_item_t'({{(10 * m3inv_pkg::WORD_BITS){1'b0}}, 1'b1});
      end else begin
        o_r.inv00 <= q[0]; o_r.inv01 <= q[1]; o_r.inv02 <= q[2];
        o_r.inv10 <= q[3]; o_r.inv11 <= q[4]; o_r.inv12 <= q[5];
        o_r.inv20 <= q[6]; o_r.inv21 <= q[7]; o_r.inv22 <= q[8];
        o_r.det_value <= dpipe_r[m3inv_pkg::DIV_LAT];
        o_r.singular  <= 1'b0;
      end
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_data  = o_r;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall mismatch");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> out_data.det_value == '0 && out_data.inv00 == '0)
    else $error("singular result not zero");
  a_det_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.singular |-> out_data.det_value != '0)
    else $error("zero det without flag");
`endif

endmodule

/* tb/matrix3x3_inverse_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker
// predicts the inverse and determinant of every accepted matrix and compares
// each accepted result with the oldest prediction, field by field
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  m3inv_pkg::in_item_t   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  m3inv_pkg::out_item_t  out_data,
  output int                    fail_count,
  output int                    pending_count,
  output int                    result_count,
  output int                    singular_count
);

  localparam longint LMAX = 64'sd2147483647;
  localparam longint LMIN = -64'sd2147483648;

  m3inv_pkg::out_item_t inverse_q[$];

  function automatic longint sat_word(input logic signed [127:0] v);
    if (v > LMAX) return LMAX;
    if (v < LMIN) return LMIN;
    return longint'(v);
  endfunction

  // rounding half away from zero
  function automatic longint q_mul(input longint a, input longint b);
    logic signed [127:0] p;
    logic signed [127:0] m;
    p = 128'(a) * 128'(b);
    m = p < 0 ? -p : p;
    m = (m + (128'sd1 <<< (m3inv_pkg::FRAC_BITS - 1))) >>> m3inv_pkg::FRAC_BITS;
    return sat_word(p < 0 ? -m : m);
  endfunction

  function automatic longint q_div(input longint n, input longint d);
    logic signed [127:0] nm;
    logic signed [127:0] dm;
    logic signed [127:0] q;
    logic signed [127:0] r;
    nm = 128'(n < 0 ? -n : n) <<< m3inv_pkg::FRAC_BITS;
    dm = 128'(d < 0 ? -d : d);
    q = nm / dm;
    r = nm - q * dm;
    if (r >= dm - r) q = q + 1;
    return sat_word(((n < 0) != (d < 0)) ? -q : q);
  endfunction

  function automatic longint cof(input longint w, input longint x, input longint y,
                                 input longint z);
    return sat_word(128'(q_mul(w, x)) - 128'(q_mul(y, z)));
  endfunction

  function automatic m3inv_pkg::out_item_t invert_matrix(input m3inv_pkg::in_item_t m);
    longint a [3][3];
    longint c [3][3];
    longint det;
    m3inv_pkg::word_t  w [3][3];
    m3inv_pkg::out_item_t o;
    a[0][0] = m.a00; a[0][1] = m.a01; a[0][2] = m.a02;
    a[1][0] = m.a10; a[1][1] = m.a11; a[1][2] = m.a12;
    a[2][0] = m.a20; a[2][1] = m.a21; a[2][2] = m.a22;
    c[0][0] = cof(a[1][1], a[2][2], a[1][2], a[2][1]);
    c[0][1] = cof(a[1][2], a[2][0], a[1][0], a[2][2]);
    c[0][2] = cof(a[1][0], a[2][1], a[1][1], a[2][0]);
    c[1][0] = cof(a[0][2], a[2][1], a[0][1], a[2][2]);
    c[1][1] = cof(a[0][0], a[2][2], a[0][2], a[2][0]);
    c[1][2] = cof(a[0][1], a[2][0], a[0][0], a[2][1]);
    c[2][0] = cof(a[0][1], a[1][2], a[0][2], a[1][1]);
    c[2][1] = cof(a[0][2], a[1][0], a[0][0], a[1][2]);
    c[2][2] = cof(a[0][0], a[1][1], a[0][1], a[1][0]);
    det = sat_word(128'(q_mul(a[0][0], c[0][0])) + 128'(q_mul(a[0][1], c[0][1])));
    det = sat_word(128'(det) + 128'(q_mul(a[0][2], c[0][2])));
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        w[r][k] = det == 0 ? '0 : m3inv_pkg::word_t'(q_div(c[k][r], det));
    o.inv00 = w[0][0]; o.inv01 = w[0][1]; o.inv02 = w[0][2];
    o.inv10 = w[1][0]; o.inv11 = w[1][1]; o.inv12 = w[1][2];
    o.inv20 = w[2][0]; o.inv21 = w[2][1]; o.inv22 = w[2][2];
    o.det_value = m3inv_pkg::word_t'(det);
    o.singular = det == 0;
    return o;
  endfunction

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    m3inv_pkg::out_item_t e;
    if (!rst_n) begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
      singular_count = 0;
    end else begin
      if (in_valid && !in_stall) inverse_q.push_back(invert_matrix(in_data));
      if (out_valid && !out_stall) begin
        result_count++;
        if (inverse_q.size() == 0) begin
          $error("result with no matrix outstanding");
          fail_count++;
        end else begin
          e = inverse_q.pop_front();
          if (e.singular) singular_count++;
          check_field("inv00", e.inv00, out_data.inv00);
          check_field("inv01", e.inv01, out_data.inv01);
          check_field("inv02", e.inv02, out_data.inv02);
          check_field("inv10", e.inv10, out_data.inv10);
          check_field("inv11", e.inv11, out_data.inv11);
          check_field("inv12", e.inv12, out_data.inv12);
          check_field("inv20", e.inv20, out_data.inv20);
          check_field("inv21", e.inv21, out_data.inv21);
          check_field("inv22", e.inv22, out_data.inv22);
          check_field("det_value", e.det_value, out_data.det_value);
          check_field("singular", e.singular, out_data.singular);
        end
      end
      pending_count = inverse_q.size();
    end
  end

endmodule

/* tb/matrix3x3_inverse_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core_tb
// drives directed and random matrices through the inverse core under several
// idle and stall patterns; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core_tb;

  localparam int  LATENCY = 55;
  localparam int  N_RANDOM = 1250;
  localparam longint CYCLE_LIMIT = 400000;
  localparam m3inv_pkg::word_t ONE = 32'sh0001_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  m3inv_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  m3inv_pkg::out_item_t out_data;

  int     fail_count;
  int     pending_count;
  int     result_count;
  int     singular_count;
  int     send_idle_pct;
  int     stall_pct;
  int     hold_cycles;
  int     hold_req;
  int     hold_seen;
  int     n_sent;
  longint cycle_count;

  matrix3x3_inverse_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  matrix3x3_inverse_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .singular_count(singular_count)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
      hold_seen <= hold_req;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cycles <= 3 * LATENCY - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic m3inv_pkg::word_t rand_word();
    case ($urandom_range(7))
      0: return m3inv_pkg::WMAX;
      1: return m3inv_pkg::WMIN;
      2: return m3inv_pkg::word_t'($urandom_range(2)) <<< m3inv_pkg::FRAC_BITS;
      3: return -(m3inv_pkg::word_t'($urandom_range(3)) <<< m3inv_pkg::FRAC_BITS);
      4: return m3inv_pkg::word_t'($urandom);
      default: return m3inv_pkg::word_t'($signed($urandom_range(32'h0006_0000))
                                         - 32'sh0003_0000);
    endcase
  endfunction

  function automatic m3inv_pkg::in_item_t rand_matrix();
    m3inv_pkg::in_item_t m;
    m = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), rand_word(), rand_word(), rand_word()};
    // dependent rows to provoke singular matrices
    case ($urandom_range(9))
      0: begin m.a20 = m.a10; m.a21 = m.a11; m.a22 = m.a12; end
      1: begin m.a00 = '0; m.a01 = '0; m.a02 = '0; end
      default: ;
    endcase
    return m;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_matrix(input m3inv_pkg::in_item_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count > 0) @(negedge clk);
  endtask

  function automatic m3inv_pkg::in_item_t diag(input m3inv_pkg::word_t d0,
                                               input m3inv_pkg::word_t d1,
                                               input m3inv_pkg::word_t d2);
    m3inv_pkg::in_item_t m;
    m = '0;
    m.a00 = d0; m.a11 = d1; m.a22 = d2;
    return m;
  endfunction

  initial begin
    m3inv_pkg::in_item_t m;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    n_sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed matrices
    send_matrix(diag(ONE, ONE, ONE));
    send_matrix('0);
    send_matrix(diag(ONE * 2, ONE * 4, -ONE / 2));
    send_matrix(diag(m3inv_pkg::WMAX, m3inv_pkg::WMAX, m3inv_pkg::WMAX));
    send_matrix(diag(m3inv_pkg::WMIN, m3inv_pkg::WMIN, m3inv_pkg::WMIN));
    send_matrix(diag(m3inv_pkg::WMIN, m3inv_pkg::WMAX, ONE));
    send_matrix({9{m3inv_pkg::WMAX}});
    send_matrix({9{m3inv_pkg::WMIN}});
    send_matrix({9{32'shFFFF_FFFF}});
    send_matrix(diag(32'sh1, 32'sh1, 32'sh1));
    send_matrix(diag(32'sh100, 32'sh100, 32'sh100));
    send_matrix(diag(ONE * 3, ONE * 3, ONE * 3));
    send_matrix(diag(ONE * 3, -ONE * 3, ONE * 7));
    send_matrix({ONE, ONE * 2, ONE * 3, ONE * 4, ONE * 5, ONE * 6,
                 ONE * 7, ONE * 8, ONE * 10});
    send_matrix({ONE, ONE * 2, ONE * 3, ONE * 4, ONE * 5, ONE * 6,
                 ONE * 7, ONE * 8, ONE * 9});
    send_matrix({32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
    send_matrix({ONE * 0, ONE, ONE * 0, ONE * 0, ONE * 0, ONE, ONE, ONE * 0, ONE * 0});
    send_matrix(diag(ONE * 200, ONE * 200, ONE * 200));
    send_matrix(diag(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000));
    drain_results();

    // long receiver hold-off while the sender keeps offering
    hold_req = hold_req + 1;
    repeat (80) send_matrix(rand_matrix());
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 46; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 46; end
        3: begin send_idle_pct = 27; stall_pct = 27; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) begin
        m = rand_matrix();
        send_matrix(m);
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (LATENCY + 10) @(negedge clk);
    $display("sent %0d matrices, checked %0d results, %0d singular",
             n_sent, result_count, singular_count);
    $display("idle patterns: none, sender 46%%, receiver 46%%, both 27%%, long hold-off");
    if (fail_count == 0 && pending_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
